/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the event histogram block.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, held off while reset is high.
`define ASSERT_CLK(label, ck, rs, prop, msg) \
  label: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, ck, prop, msg) \
  label: assert property (@(posedge ck) prop) else $error(msg);

`endif

/* rtl/ehh_pkg.sv */
// Shared constants for the event histogram / heatmap accumulator.
// No dependencies; imported by ehh_bin_div and the top level.
package ehh_pkg;

  localparam int TIME_W   = 64;
  localparam int TICK_W   = 32;
  localparam int CNT_W    = 32;
  localparam int PIX_IN_W = 16;
  localparam int RIDX_W   = 19;
  localparam int BIN_W    = 12;               // width of bins_in_use, so bins stay below 4096
  localparam int DVD_W    = TICK_W + BIN_W;   // dividend width once quotient < 2**BIN_W

  localparam int S_TDATA_W = 120;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 64;

  localparam logic [1:0] OP_COUNT = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] STAT_COUNTED = 2'd0;
  localparam logic [1:0] STAT_DROPPED = 2'd1;
  localparam logic [1:0] STAT_READ    = 2'd2;
  localparam logic [1:0] STAT_CLEARED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BINS  = 2'd3;

  localparam logic [TICK_W-1:0] TICKS_RESET = 32'd1000;
  localparam logic [BIN_W-1:0]  BINS_RESET  = 12'd2000;

endpackage

/* rtl/ehh_bin_div.sv */
// Restoring divider for the bin number, one quotient bit per cycle.
// Depends on ehh_pkg. Caller guarantees dividend < divisor * 2**BIN_W.
module ehh_bin_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ehh_pkg::DVD_W-1:0]   dividend,
  input  logic [ehh_pkg::TICK_W-1:0]  divisor,
  output logic                        done,
  output logic [ehh_pkg::BIN_W-1:0]   quotient
);
  import ehh_pkg::*;

  localparam int STEP_W = $clog2(BIN_W + 1);

  logic [DVD_W-1:0]  rem;
  logic [DVD_W-1:0]  dsh;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic              ge;

  assign ge = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= dividend;
        dsh      <= DVD_W'({divisor, {(BIN_W-1){1'b0}}});
        quotient <= '0;
        steps    <= STEP_W'(BIN_W);
        busy     <= 1'b1;
      end else if (busy) begin
        if (ge) begin
          rem <= rem - dsh;
        end
        quotient <= {quotient[BIN_W-2:0], ge};
        dsh      <= dsh >> 1;
        steps    <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/ehh_counter_mem.sv */
// Counter store: single-port synchronous RAM with a registered read; data is valid in the cycle after re.
// No dependencies.
module ehh_counter_mem #(
  parameter int DEPTH  = 307200,
  parameter int ADDR_W = 19
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [31:0]       wdata,
  output logic [31:0]       rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* rtl/event_histogram_heatmap_accumulator_top.sv */
// Top level of the event histogram / heatmap accumulator.
// Depends on ehh_pkg, ehh_bin_div, ehh_counter_mem and assert_macros.svh.
//
//  channel  dir  handshake             payload
//  s_*      in   s_tvalid / s_tready   s_tuser opcode, s_tdata event fields
//  m_*      out  m_tvalid / m_tready   m_tuser status, m_tdata counter_value
//  cfg_*    in   cfg_valid / cfg_ready cfg_index register, cfg_data value
//
// One item at a time. Read and pixel items pass DECODE, RD and MOD to WAIT; time-mode
// events add TCHK and DIV, the 12-step bin divider; clear first runs the clearing pass.
// Early drops leave DECODE or TCHK, bins past range DIV; s_tready returns with m_tvalid.
// After reset a clearing pass writes zero to every counter, one per cycle
// (STORE_DEPTH counters, 307200 at the default frame); s_tready stays low meanwhile.
// A held result sits in the output register while the next item is accepted.
`include "assert_macros.svh"

module event_histogram_heatmap_accumulator_top #(
  parameter int FRAME_WIDTH  = 640,
  parameter int FRAME_HEIGHT = 480,
  parameter int MAX_BINS     = 2048
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [63:0] event_time, [79:64] pixel_x, [95:80] pixel_y, [114:96] read_index
  input  logic [ehh_pkg::S_TDATA_W-1:0]    s_tdata,
  // [1:0] opcode
  input  logic [1:0]                       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [31:0] counter_value
  output logic [ehh_pkg::CNT_W-1:0]        m_tdata,
  // [1:0] status
  output logic [1:0]                       m_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ehh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ehh_pkg::CFG_DAT_W-1:0]    cfg_data
);
  import ehh_pkg::*;

  localparam int PIXEL_COUNT = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int STORE_DEPTH = (PIXEL_COUNT > MAX_BINS) ? PIXEL_COUNT : MAX_BINS;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int XW          = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int YW          = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
  localparam int PIX_W       = XW + YW + 1;
  localparam int MB_W        = 17;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_DECODE = 3'd2;
  localparam logic [2:0] ST_TCHK   = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_RD     = 3'd5;
  localparam logic [2:0] ST_MOD    = 3'd6;
  localparam logic [2:0] ST_WAIT   = 3'd7;

  // configuration
  logic                accumulate_mode;
  logic [TIME_W-1:0]   start_timestamp;
  logic [TICK_W-1:0]   ticks_per_bin;
  logic [BIN_W-1:0]    bins_in_use;

  // sequencer
  logic [2:0]          state;
  logic [ADDR_W-1:0]   addr;
  logic                clr_report;
  logic [1:0]          it_op;
  logic [TIME_W-1:0]   it_time;
  logic [PIX_IN_W-1:0] it_px;
  logic [PIX_IN_W-1:0] it_py;
  logic [RIDX_W-1:0]   it_ridx;
  logic [TIME_W-1:0]   diff;
  logic [1:0]          res_status;
  logic [CNT_W-1:0]    res_value;

  logic [TIME_W:0]     sub;
  logic [TICK_W-1:0]   div_eff;
  logic [TIME_W-1:0]   span;
  logic                too_far;
  logic                pix_ok;
  logic [ADDR_W-1:0]   pix_addr;
  logic                ridx_ok;
  logic                div_start;
  logic                div_done;
  logic [BIN_W-1:0]    quot;
  logic                bin_ok;
  logic                mem_we;
  logic                mem_re;
  logic [CNT_W-1:0]    mem_wdata;
  logic [CNT_W-1:0]    mem_rdata;
  logic                out_free;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;

  // borrow out of the subtraction flags an event before the start time
  assign sub     = {1'b0, it_time} - {1'b0, start_timestamp};
  assign div_eff = (ticks_per_bin == '0) ? TICK_W'(1) : ticks_per_bin;
  assign span    = {{(TIME_W-TICK_W-BIN_W){1'b0}}, div_eff, {BIN_W{1'b0}}};
  assign too_far = diff >= span;

  assign pix_ok   = (it_px < PIX_IN_W'(FRAME_WIDTH)) && (it_py < PIX_IN_W'(FRAME_HEIGHT));
  assign pix_addr = ADDR_W'(PIX_W'(it_px[XW-1:0]) * PIX_W'(FRAME_HEIGHT)
                            + PIX_W'(it_py[YW-1:0]));
  assign ridx_ok  = 32'(it_ridx) < 32'(STORE_DEPTH);
  assign bin_ok   = (quot < bins_in_use) && (MB_W'(quot) < MB_W'(MAX_BINS));

  assign div_start = (state == ST_TCHK) && !too_far;

  assign mem_re    = (state == ST_RD);
  assign mem_we    = (state == ST_CLEAR) || ((state == ST_MOD) && (it_op == OP_COUNT));
  assign mem_wdata = (state == ST_CLEAR) ? '0 : mem_rdata + 1'b1;

  ehh_bin_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff[DVD_W-1:0]),
    .divisor  (div_eff),
    .done     (div_done),
    .quotient (quot)
  );

  ehh_counter_mem #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulate_mode <= 1'b0;
      start_timestamp <= '0;
      ticks_per_bin   <= TICKS_RESET;
      bins_in_use     <= BINS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:  accumulate_mode <= cfg_data[0];
        REG_START: start_timestamp <= cfg_data;
        REG_TICKS: ticks_per_bin   <= cfg_data[TICK_W-1:0];
        REG_BINS:  bins_in_use     <= cfg_data[BIN_W-1:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      addr       <= '0;
      clr_report <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // WAIT loads the output register itself
      if (m_tvalid && m_tready && (state != ST_WAIT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          addr <= addr + 1'b1;
          if (addr == LAST_ADDR) begin
            if (clr_report) begin
              res_status <= STAT_CLEARED;
              res_value  <= '0;
              state      <= ST_WAIT;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            it_op   <= s_tuser;
            it_time <= s_tdata[63:0];
            it_px   <= s_tdata[79:64];
            it_py   <= s_tdata[95:80];
            it_ridx <= s_tdata[114:96];
            state   <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          unique case (it_op)
            OP_COUNT: begin
              if (!accumulate_mode && !sub[TIME_W]) begin
                diff  <= sub[TIME_W-1:0];
                state <= ST_TCHK;
              end else if (accumulate_mode && pix_ok) begin
                addr  <= pix_addr;
                state <= ST_RD;
              end else begin
                res_status <= STAT_DROPPED;
                res_value  <= '0;
                state      <= ST_WAIT;
              end
            end
            OP_READ: begin
              if (ridx_ok) begin
                addr  <= ADDR_W'(it_ridx);
                state <= ST_RD;
              end else begin
                res_status <= STAT_DROPPED;
                res_value  <= '0;
                state      <= ST_WAIT;
              end
            end
            OP_CLEAR: begin
              addr       <= '0;
              clr_report <= 1'b1;
              state      <= ST_CLEAR;
            end
            default: begin
              res_status <= STAT_DROPPED;
              res_value  <= '0;
              state      <= ST_WAIT;
            end
          endcase
        end
        ST_TCHK: begin
          if (too_far) begin
            res_status <= STAT_DROPPED;
            res_value  <= '0;
            state      <= ST_WAIT;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            if (bin_ok) begin
              addr  <= ADDR_W'(quot);
              state <= ST_RD;
            end else begin
              res_status <= STAT_DROPPED;
              res_value  <= '0;
              state      <= ST_WAIT;
            end
          end
        end
        ST_RD: begin
          state <= ST_MOD;
        end
        ST_MOD: begin
          if (it_op == OP_READ) begin
            res_status <= STAT_READ;
            res_value  <= mem_rdata;
          end else begin
            res_status <= STAT_COUNTED;
            res_value  <= mem_wdata;
          end
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res_value;
            m_tuser  <= res_status;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_one_item, clk, rst, (s_tvalid && s_tready) |=> !s_tready, "accepted twice in a row")
  `ASSERT_CLK(a_addr_range, clk, rst, mem_we |-> (addr <= LAST_ADDR), "store write out of range")
  `ASSERT_CLK(a_div_owner, clk, rst, div_done |-> (state == ST_DIV), "divider done outside DIV")
  `ASSERT_CLK(a_no_write_idle, clk, rst, (state == ST_IDLE) |-> !mem_we, "store written while idle")

endmodule
